@@ rtl/assert_macros.svh @@
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

@@ rtl/pps_pkg.sv @@
package pps_pkg;
    localparam int MaxPieceVertsDefault = 128;
    localparam int MinPieceVerts = 3;
    localparam int TFrac = 28;
    localparam int DistW = 40;

    localparam logic [2:0] RegNormalX = 3'd0;
    localparam logic [2:0] RegNormalY = 3'd1;
    localparam logic [2:0] RegNormalZ = 3'd2;
    localparam logic [2:0] RegOffset  = 3'd3;
    localparam logic [2:0] RegBand    = 3'd4;
endpackage

@@ rtl/polygon_plane_split_top.sv @@
// Channel | valid    | stall    | payload
// in      | in_valid | in_stall | px py pz closing
// out     | out_valid| out_stall| qx qy qz flags totals end_of_run
// cfg     | cfg_we   | -        | cfg_index cfg_data
// Distance: the shared multiplier accumulates the x, y and z products, then the offset is subtracted.
// Each crossing: the restoring divider forms t, a multiplier interpolates x, y and z, then the point is emitted.
// A new vertex is taken only once the previous one, its crossings and any summary are out;
// in_stall is high meanwhile, and a record held by out_stall holds the whole split.
// Reset sets the configuration registers to their reset values and clears state, counters and out_valid.
`include "assert_macros.svh"
module polygon_plane_split_top
    import pps_pkg::*;
#(
    parameter int MAX_PIECE_VERTS = MaxPieceVertsDefault
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] px,
    input  logic signed [31:0] py,
    input  logic signed [31:0] pz,
    input  logic               closing,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] qx,
    output logic signed [31:0] qy,
    output logic signed [31:0] qz,
    output logic               to_front,
    output logic               to_back,
    output logic               is_crossing,
    output logic               is_summary,
    output logic [7:0]         front_total,
    output logic [7:0]         back_total,
    output logic               front_ok,
    output logic               back_ok,
    output logic               end_of_run,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    localparam logic [7:0] MaxV = 8'(MAX_PIECE_VERTS);
    localparam logic [7:0] MinV = 8'(MinPieceVerts);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_DIST, S_CHK1, S_DIV, S_LERP, S_PUTX, S_VERT,
        S_CHK2, S_SUM, S_WAIT
    } state_t;

    state_t state_reg;
    logic signed [15:0] nx_reg, ny_reg, nz_reg;
    logic signed [31:0] off_reg;
    logic [15:0] band_reg;
    logic signed [31:0] cx_reg, cy_reg, cz_reg, fx_reg, fy_reg, fz_reg;
    logic signed [31:0] vx_reg, vy_reg, vz_reg;
    logic signed [DistW-1:0] fd_reg, pd_reg, cd_reg;
    logic have_prev_reg, last_reg, close_edge_reg;
    logic [7:0] fs_reg, bs_reg;
    logic [1:0] k_reg;
    logic signed [49:0] acc_reg;
    logic signed [31:0] ax_reg, ay_reg, az_reg, bx_reg, by_reg, bz_reg;
    logic signed [DistW-1:0] da_reg, db_reg;
    logic [68:0] rem_reg;
    logic [28:0] t_reg;
    logic [40:0] den_reg;
    logic [4:0] it_reg;
    logic signed [31:0] r0_reg, r1_reg, r2_reg;
    logic signed [31:0] ox_reg, oy_reg, oz_reg;
    logic of_reg, ob_reg, oc_reg, os_reg, oe_reg;
    logic [7:0] oft_reg, obt_reg;
    logic ofo_reg, obo_reg, ov_reg;

    // shared multiplier
    logic signed [31:0] ma;
    logic signed [15:0] mb;
    logic signed [47:0] mp;
    logic signed [32:0] diff;
    logic [32:0] dmag;
    logic [61:0] lp;
    logic signed [31:0] la, lres;
    logic signed [DistW-1:0] band_s, dsum;
    logic [40:0] ada;
    logic signed [DistW-1:0] dd;
    logic [40:0] dden;
    logic [69:0] trial;
    logic emit;

    always_comb
    begin
        unique case (k_reg)
            2'd0: begin ma = cx_reg; mb = nx_reg; end
            2'd1: begin ma = cy_reg; mb = ny_reg; end
            default: begin ma = cz_reg; mb = nz_reg; end
        endcase
        mp = ma * mb;
        unique case (k_reg)
            2'd0: begin la = ax_reg; diff = 33'(bx_reg) - 33'(ax_reg); end
            2'd1: begin la = ay_reg; diff = 33'(by_reg) - 33'(ay_reg); end
            default: begin la = az_reg; diff = 33'(bz_reg) - 33'(az_reg); end
        endcase
        dmag = diff[32] ? 33'(-diff) : diff;
        lp = 62'(dmag) * 62'(t_reg);
        lres = diff[32] ? 32'(33'(la) - 33'(lp[61:TFrac]))
                        : 32'(33'(la) + 33'(lp[61:TFrac]));
        band_s = DistW'(band_reg);
        dsum = DistW'(acc_reg >>> 14) - DistW'(off_reg);
        ada = da_reg[DistW-1] ? 41'(-da_reg) : 41'(da_reg);
        dd = da_reg - db_reg;
        dden = dd[DistW-1] ? 41'(-dd) : 41'(dd);
        trial = {rem_reg, 1'b0} - {29'd0, den_reg};
        emit = (state_reg == S_PUTX || state_reg == S_VERT || state_reg == S_SUM)
               && (!ov_reg || !out_stall);
    end

    function automatic logic crosses(input logic signed [DistW-1:0] a,
                                     input logic signed [DistW-1:0] b,
                                     input logic signed [DistW-1:0] e);
        crosses = (a > e && b < -e) || (a < -e && b > e);
    endfunction

    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = ov_reg;
    assign qx = ox_reg; assign qy = oy_reg; assign qz = oz_reg;
    assign to_front = of_reg; assign to_back = ob_reg;
    assign is_crossing = oc_reg; assign is_summary = os_reg;
    assign front_total = oft_reg; assign back_total = obt_reg;
    assign front_ok = ofo_reg; assign back_ok = obo_reg;
    assign end_of_run = oe_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            nx_reg <= 16'sd16384; ny_reg <= '0; nz_reg <= '0;
            off_reg <= '0; band_reg <= 16'd655;
            fx_reg <= '0; fy_reg <= '0; fz_reg <= '0; fd_reg <= '0;
            vx_reg <= '0; vy_reg <= '0; vz_reg <= '0; pd_reg <= '0;
            have_prev_reg <= 1'b0; fs_reg <= '0; bs_reg <= '0;
            ov_reg <= 1'b0; k_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    RegNormalX: nx_reg <= cfg_data[15:0];
                    RegNormalY: ny_reg <= cfg_data[15:0];
                    RegNormalZ: nz_reg <= cfg_data[15:0];
                    RegOffset:  off_reg <= cfg_data;
                    RegBand:    band_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (emit)
                ov_reg <= 1'b1;
            else if (!out_stall)
                ov_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    if (in_valid)
                    begin
                        cx_reg <= px; cy_reg <= py; cz_reg <= pz; last_reg <= closing;
                        acc_reg <= '0; k_reg <= '0; state_reg <= S_MUL;
                    end
                S_MUL:
                begin
                    acc_reg <= acc_reg + 50'(mp);
                    if (k_reg == 2'd2) state_reg <= S_DIST;
                    else k_reg <= k_reg + 2'd1;
                end
                S_DIST:
                begin
                    cd_reg <= dsum;
                    state_reg <= S_CHK1;
                end
                S_CHK1:
                    if (have_prev_reg && crosses(pd_reg, cd_reg, band_s))
                    begin
                        ax_reg <= vx_reg; ay_reg <= vy_reg; az_reg <= vz_reg;
                        da_reg <= pd_reg;
                        bx_reg <= cx_reg; by_reg <= cy_reg; bz_reg <= cz_reg;
                        db_reg <= cd_reg; close_edge_reg <= 1'b0;
                        it_reg <= '0; rem_reg <= '0; state_reg <= S_DIV;
                        den_reg <= '0;
                    end
                    else state_reg <= S_VERT;
                S_DIV:
                begin
                    if (it_reg == 5'd0)
                    begin
                        den_reg <= dden;
                        rem_reg <= 69'(ada);
                        t_reg <= '0;
                        it_reg <= 5'd1;
                    end
                    else
                    begin
                        if (!trial[69])
                        begin
                            rem_reg <= trial[68:0];
                            t_reg <= {t_reg[27:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= {rem_reg[67:0], 1'b0};
                            t_reg <= {t_reg[27:0], 1'b0};
                        end
                        it_reg <= it_reg + 5'd1;
                        if (it_reg == 5'd28)
                        begin
                            k_reg <= '0; state_reg <= S_LERP;
                        end
                    end
                end
                S_LERP:
                begin
                    unique case (k_reg)
                        2'd0: r0_reg <= lres;
                        2'd1: r1_reg <= lres;
                        default: r2_reg <= lres;
                    endcase
                    if (k_reg == 2'd2) state_reg <= S_PUTX;
                    else k_reg <= k_reg + 2'd1;
                end
                S_PUTX:
                    if (!ov_reg || !out_stall)
                    begin
                        ox_reg <= r0_reg; oy_reg <= r1_reg; oz_reg <= r2_reg;
                        of_reg <= fs_reg < MaxV; ob_reg <= bs_reg < MaxV;
                        if (fs_reg < MaxV) fs_reg <= fs_reg + 8'd1;
                        if (bs_reg < MaxV) bs_reg <= bs_reg + 8'd1;
                        oc_reg <= 1'b1; os_reg <= 1'b0; oe_reg <= 1'b0;
                        oft_reg <= '0; obt_reg <= '0; ofo_reg <= 1'b0; obo_reg <= 1'b0;
                        state_reg <= close_edge_reg ? S_SUM : S_VERT;
                    end
                S_VERT:
                    if (!ov_reg || !out_stall)
                    begin : vert
                        logic f, b;
                        f = (cd_reg >= -band_s) && (fs_reg < MaxV);
                        b = (cd_reg <= band_s) && (bs_reg < MaxV);
                        ox_reg <= cx_reg; oy_reg <= cy_reg; oz_reg <= cz_reg;
                        of_reg <= f; ob_reg <= b;
                        if (f) fs_reg <= fs_reg + 8'd1;
                        if (b) bs_reg <= bs_reg + 8'd1;
                        oc_reg <= 1'b0; os_reg <= 1'b0; oe_reg <= !last_reg;
                        oft_reg <= '0; obt_reg <= '0; ofo_reg <= 1'b0; obo_reg <= 1'b0;
                        vx_reg <= cx_reg; vy_reg <= cy_reg; vz_reg <= cz_reg;
                        pd_reg <= cd_reg;
                        if (!have_prev_reg)
                        begin
                            fx_reg <= cx_reg; fy_reg <= cy_reg; fz_reg <= cz_reg;
                            fd_reg <= cd_reg;
                        end
                        have_prev_reg <= 1'b1;
                        state_reg <= last_reg ? S_CHK2 : S_WAIT;
                    end
                S_CHK2:
                    if (crosses(cd_reg, fd_reg, band_s))
                    begin
                        ax_reg <= cx_reg; ay_reg <= cy_reg; az_reg <= cz_reg;
                        da_reg <= cd_reg;
                        bx_reg <= fx_reg; by_reg <= fy_reg; bz_reg <= fz_reg;
                        db_reg <= fd_reg; close_edge_reg <= 1'b1;
                        it_reg <= '0; rem_reg <= '0; den_reg <= '0;
                        state_reg <= S_DIV;
                    end
                    else state_reg <= S_SUM;
                S_SUM:
                    if (!ov_reg || !out_stall)
                    begin
                        ox_reg <= '0; oy_reg <= '0; oz_reg <= '0;
                        of_reg <= 1'b0; ob_reg <= 1'b0; oc_reg <= 1'b0;
                        os_reg <= 1'b1; oe_reg <= 1'b1;
                        oft_reg <= fs_reg; obt_reg <= bs_reg;
                        ofo_reg <= fs_reg >= MinV; obo_reg <= bs_reg >= MinV;
                        fs_reg <= '0; bs_reg <= '0; have_prev_reg <= 1'b0;
                        state_reg <= S_WAIT;
                    end
                S_WAIT:
                    if (!ov_reg || !out_stall) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `ASSERT_IMPL(a_busy_stall, clk, rst_n, state_reg != S_IDLE, in_stall)
    `ASSERT_IMPL(a_count_cap, clk, rst_n, 1'b1, fs_reg <= MaxV && bs_reg <= MaxV)
    `ASSERT_NEXT(a_hold, clk, rst_n, ov_reg && out_stall, ov_reg && $stable(ox_reg))
endmodule

@@ test/tb_polygon_plane_split_top.sv @@
module tb_polygon_plane_split_top
    import pps_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PieceMax = MaxPieceVertsDefault;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               closing;
    } vertex_t;

    typedef struct packed {
        logic signed [31:0] qx;
        logic signed [31:0] qy;
        logic signed [31:0] qz;
        logic               to_front;
        logic               to_back;
        logic               is_crossing;
        logic               is_summary;
        logic [7:0]         front_total;
        logic [7:0]         back_total;
        logic               front_ok;
        logic               back_ok;
        logic               end_of_run;
    } piece_rec_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [31:0] px = '0, py = '0, pz = '0;
    logic closing = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [31:0] qx, qy, qz;
    logic to_front, to_back, is_crossing, is_summary;
    logic [7:0] front_total, back_total;
    logic front_ok, back_ok, end_of_run;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    polygon_plane_split_top u_top (.*);

    always #2 clk = ~clk;

    vertex_t    vertex_q[$];
    piece_rec_t split_q[$];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // split state
    logic signed [63:0] nx = 16384, ny = 0, nz = 0, offs = 0, band = 655;
    logic signed [63:0] fx, fy, fz, fdist, vx, vy, vz, vdist;
    bit   have_prev = 0;
    int   front_cnt = 0, back_cnt = 0;

    function automatic logic signed [63:0] point_distance(logic signed [63:0] x,
        logic signed [63:0] y, logic signed [63:0] z);
        logic signed [63:0] s;
        s = nx * x + ny * y + nz * z;
        return (s >>> 14) - offs;
    endfunction

    function automatic bit edge_crosses(logic signed [63:0] a, logic signed [63:0] b);
        return (a > band && b < -band) || (a < -band && b > band);
    endfunction

    function automatic logic [63:0] abs64(logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic signed [63:0] lerp(logic signed [63:0] a,
        logic signed [63:0] b, logic [63:0] t);
        logic signed [63:0] diff;
        logic [63:0] p;
        diff = b - a;
        p = (abs64(diff) * t) >> TFrac;
        return diff < 0 ? a - $signed(p) : a + $signed(p);
    endfunction

    function automatic bit take_front();
        if (front_cnt < PieceMax) begin front_cnt++; return 1; end
        return 0;
    endfunction

    function automatic bit take_back();
        if (back_cnt < PieceMax) begin back_cnt++; return 1; end
        return 0;
    endfunction

    task automatic push_crossing(logic signed [63:0] ax, logic signed [63:0] ay,
        logic signed [63:0] az, logic signed [63:0] da, logic signed [63:0] bx,
        logic signed [63:0] by, logic signed [63:0] bz, logic signed [63:0] db);
        logic [63:0] t;
        piece_rec_t r;
        t = (abs64(da) << TFrac) / abs64(da - db);
        r = '0;
        r.qx = 32'(lerp(ax, bx, t));
        r.qy = 32'(lerp(ay, by, t));
        r.qz = 32'(lerp(az, bz, t));
        r.to_front = take_front();
        r.to_back = take_back();
        r.is_crossing = 1'b1;
        split_q.push_back(r);
    endtask

    task automatic predict_split(vertex_t v);
        logic signed [63:0] x, y, z, d;
        piece_rec_t r;
        x = v.x;
        y = v.y;
        z = v.z;
        d = point_distance(x, y, z);
        if (have_prev && edge_crosses(vdist, d))
            push_crossing(vx, vy, vz, vdist, x, y, z, d);
        r = '0;
        r.qx = v.x;
        r.qy = v.y;
        r.qz = v.z;
        if (d >= -band) r.to_front = take_front();
        if (d <= band) r.to_back = take_back();
        split_q.push_back(r);
        if (!have_prev) begin
            fx = x; fy = y; fz = z; fdist = d;
        end
        vx = x; vy = y; vz = z; vdist = d;
        have_prev = 1;
        if (v.closing) begin
            if (edge_crosses(d, fdist))
                push_crossing(x, y, z, d, fx, fy, fz, fdist);
            r = '0;
            r.is_summary = 1'b1;
            r.front_total = front_cnt[7:0];
            r.back_total = back_cnt[7:0];
            r.front_ok = front_cnt >= MinPieceVerts;
            r.back_ok = back_cnt >= MinPieceVerts;
            split_q.push_back(r);
            have_prev = 0;
            front_cnt = 0;
            back_cnt = 0;
        end
        split_q[$].end_of_run = 1'b1;
    endtask

    // driver
    always @(posedge clk) begin
        if (rst_n) begin
            if (!in_valid || !in_stall) begin
                if (vertex_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    vertex_t v;
                    v = vertex_q.pop_front();
                    predict_split(v);
                    in_valid <= 1'b1;
                    px <= v.x;
                    py <= v.y;
                    pz <= v.z;
                    closing <= v.closing;
                end else begin
                    in_valid <= 1'b0;
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // monitor
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (split_q.size() == 0) begin
                $error("unexpected transfer on output");
                errors++;
            end else begin
                piece_rec_t e;
                e = split_q.pop_front();
                if (qx !== e.qx) begin
                    $error("qx exp %0d got %0d", e.qx, qx); errors++; end
                if (qy !== e.qy) begin
                    $error("qy exp %0d got %0d", e.qy, qy); errors++; end
                if (qz !== e.qz) begin
                    $error("qz exp %0d got %0d", e.qz, qz); errors++; end
                if (to_front !== e.to_front) begin
                    $error("to_front exp %0b got %0b", e.to_front, to_front); errors++; end
                if (to_back !== e.to_back) begin
                    $error("to_back exp %0b got %0b", e.to_back, to_back); errors++; end
                if (is_crossing !== e.is_crossing) begin
                    $error("is_crossing exp %0b got %0b", e.is_crossing, is_crossing);
                    errors++;
                end
                if (is_summary !== e.is_summary) begin
                    $error("is_summary exp %0b got %0b", e.is_summary, is_summary);
                    errors++;
                end
                if (front_total !== e.front_total) begin
                    $error("front_total exp %0d got %0d", e.front_total, front_total);
                    errors++;
                end
                if (back_total !== e.back_total) begin
                    $error("back_total exp %0d got %0d", e.back_total, back_total);
                    errors++;
                end
                if (front_ok !== e.front_ok) begin
                    $error("front_ok exp %0b got %0b", e.front_ok, front_ok); errors++; end
                if (back_ok !== e.back_ok) begin
                    $error("back_ok exp %0b got %0b", e.back_ok, back_ok); errors++; end
                if (end_of_run !== e.end_of_run) begin
                    $error("end_of_run exp %0b got %0b", e.end_of_run, end_of_run);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            RegNormalX: nx = $signed(data[15:0]);
            RegNormalY: ny = $signed(data[15:0]);
            RegNormalZ: nz = $signed(data[15:0]);
            RegOffset:  offs = $signed(data);
            RegBand:    band = data[15:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        wait (vertex_q.size() == 0 && split_q.size() == 0);
        repeat (60) @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(0, 'h1FFFFF)) - 'h100000;
            default: return $signed($urandom_range(0, 'h3FFFF)) - 'h20000;
        endcase
    endfunction

    task automatic add_vertex(logic signed [31:0] x, logic signed [31:0] y,
        logic signed [31:0] z, logic c);
        vertex_t v;
        v.x = x; v.y = y; v.z = z; v.closing = c;
        vertex_q.push_back(v);
    endtask

    task automatic add_polygon(int n, int mode);
        for (int i = 0; i < n; i++)
            add_vertex(rand_coord(mode), rand_coord(mode), rand_coord(mode), i == n - 1);
    endtask

    task automatic random_plane();
        int m;
        m = $urandom_range(3);
        write_reg(RegNormalX, m == 0 ? 32'hFFFF8000 : $urandom_range(0, 32768) - 16384);
        write_reg(RegNormalY, $urandom_range(0, 32768) - 16384);
        write_reg(RegNormalZ, $urandom_range(0, 32768) - 16384);
        write_reg(RegOffset, m == 1 ? $urandom : $urandom_range(0, 'h40000) - 'h20000);
        write_reg(RegBand, m == 2 ? 32'hFFFF : (m == 3 ? 0 : $urandom_range(0, 4000)));
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 17;
        recv_idle_pct = 79;

        // directed, reset plane x = 0
        add_vertex(32'sh10000, 0, 0, 1);
        add_vertex(-32'sh20000, 5, 7, 0);
        add_vertex(32'sh30000, -3, 2, 0);
        add_vertex(32'sh100, 9, 9, 0);
        add_vertex(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 1);
        add_vertex(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 0);
        add_vertex(32'sh7FFFFFFF, 0, -1, 0);
        add_vertex(-32'sh10000, 1, 1, 1);
        add_vertex(0, 0, 0, 0);
        add_vertex(32'sh10, 0, 0, 1);
        drain();
        write_reg(RegNormalX, 32'h00008000);
        write_reg(RegNormalY, 32'h00004000);
        write_reg(RegNormalZ, 32'hFFFFC000);
        write_reg(RegOffset, 32'h80000000);
        write_reg(RegBand, 32'h0000FFFF);
        add_vertex(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 0);
        add_vertex(32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 0);
        add_vertex(0, 0, 0, 1);
        drain();
        write_reg(RegNormalX, 32'h4000);
        write_reg(RegNormalY, 0);
        write_reg(RegNormalZ, 0);
        write_reg(RegOffset, 0);
        write_reg(RegBand, 0);
        // piece overflow: alternating sides
        for (int i = 0; i < 140; i++)
            add_vertex((i % 2) ? 32'sh10000 : -32'sh10000, i, -i, i == 139);
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin send_idle_pct = 79; recv_idle_pct = 17; end
            if (phase == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
            for (int k = 0; k < 3; k++) begin
                random_plane();
                repeat (4) begin
                    int n;
                    n = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 8);
                    add_polygon(n, $urandom_range(2));
                end
                drain();
            end
        end
        drain();
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end
endmodule
